// ----- src/bffa_pkg.sv -----
// Shared types and constants of the bitmap first-fit allocator.
package bffa_pkg;

  // Field widths fixed by the command and result formats
  localparam int unsigned REQ_W      = 17;
  localparam int unsigned HDR_W      = 8;
  localparam int unsigned RSV_W      = 11;
  localparam int unsigned START_W    = 10;
  localparam int unsigned FREE_OUT_W = 11;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Bitmap digit: units examined per scan cycle, one memory word
  localparam int unsigned DIGIT  = 8;
  localparam int unsigned DIG_SH = 3;
  localparam int unsigned CNT_W  = 4;

  // Unit-count numerator and quotient width, bit counter width
  localparam int unsigned NUM_W  = 18;
  localparam int unsigned DCNT_W = 5;

  // Extended unit index, wide enough for start plus any run length
  localparam int unsigned XW = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

  // Register reset values
  localparam logic [HDR_W-1:0] HDR_RESET = 8'd48;
  localparam logic [RSV_W-1:0] RSV_RESET = 11'd1;

  // Command kinds and result status codes
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [REQ_W-1:0]   request_bytes;
    logic [START_W-1:0] start_unit;
  } cmd_t;

  typedef struct packed {
    logic                  status;
    logic [START_W-1:0]    granted_unit;
    logic [FREE_OUT_W-1:0] free_units;
    logic                  region_empty;
  } res_t;

endpackage

// ----- src/bitmap_first_fit_allocator.sv -----
// Top level: bitmap first-fit unit allocator with digit-serial bitmap scan.
//
// Commands enter on cmd_i and are taken at a rising edge with start high and
// busy low. Each command yields one result on res_o, shown for exactly one
// cycle with done_o high; the receiver cannot stall and the result is taken
// at the edge that ends that cycle. busy stays high from the transfer until
// the cycle in which the result is shown, when a new command may already be
// taken. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are taken
// at once: index 0 sets the header bytes, index 1 the reserved units, which
// also wipes the bitmap and reloads the free count.
// Steps: bit-serial unit-count division over NUM_W (18) quotient bits, then for
// an allocate a scan of bitmap words of DIGIT units each (up to
// ceil(NUM_UNITS/8), 128 by default) and the marking of the words of the run,
// and for a release the clearing of the words of the run.
// The scan reads the bitmap memory one word a cycle.
// After reset, and after each reserved-units write, a clearing pass
// zeroes the bitmap word by word with busy high.
module bitmap_first_fit_allocator
  import bffa_pkg::*;
#(
  parameter int unsigned NUM_UNITS  = 1024,
  parameter int unsigned UNIT_BYTES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd_i,
  output logic                  done_o,
  output res_t                  res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = (NUM_UNITS + DIGIT - 1) / DIGIT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW    = $clog2(NUM_UNITS + 1);
  localparam int unsigned RW    = $clog2(UNIT_BYTES) + 1;

  localparam logic [XW-1:0]    NUM_X  = XW'(NUM_UNITS);
  localparam logic [NUM_W-1:0] UB_M1  = NUM_W'(UNIT_BYTES - 1);
  localparam logic [RW:0]      UB_R   = (RW + 1)'(UNIT_BYTES);
  localparam logic [AW-1:0]    LAST_W = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_CHECK, S_SCANP, S_SCAN,
    S_FOUND, S_RCNT, S_MPRIME, S_MOD, S_DONE
  } state_e;

  state_e state_q;

  logic [HDR_W-1:0]   hdr_q;
  logic [RSV_W-1:0]   rsv_q;
  logic [FW-1:0]      cap_q, free_q;
  logic               kind_q, fail_q;
  logic [START_W-1:0] first_q;
  logic [NUM_W-1:0]   num_q, n_q, run_q;
  logic [RW-1:0]      rem_q;
  logic [DCNT_W-1:0]  cnt_q;
  logic [XW-1:0]      lo_q, hi_q, added_q;
  logic [AW-1:0]      wi_q, rd_ptr_q, last_q;
  logic [DIGIT-1:0]   rd_data_q;
  logic               done_q;
  res_t               res_q;

  // Bitmap memory, one digit of units per word
  logic [DIGIT-1:0] mem_q [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [DIGIT-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_ptr_q];
  end

  // Division step: restoring, one quotient bit a cycle
  logic [RW:0]   rem_sh, rem_sub;
  logic          div_ge;
  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    div_ge  = (rem_sh >= UB_R);
    rem_sub = rem_sh - UB_R;
  end

  // Per-unit view of the word in the read register
  logic [XW-1:0]    base_x;
  logic [XW-1:0]    unit_b [DIGIT];
  logic [DIGIT-1:0] taken, mod_mask, nmask, win_ok;
  logic [CNT_W-1:0] lowfree, hifree;
  logic             stop_lo, stop_hi, n_small, win_any, cont_hit;
  logic [DIG_SH-1:0] win_p;
  logic [NUM_W:0]   run_ext;

  always_comb begin
    base_x = XW'(wi_q) << DIG_SH;
    for (int b = 0; b < DIGIT; b++) begin
      unit_b[b]   = base_x + XW'(b);
      taken[b]    = rd_data_q[b] | (unit_b[b] < XW'(rsv_q)) | (unit_b[b] >= NUM_X);
      mod_mask[b] = (unit_b[b] >= lo_q) && (unit_b[b] < hi_q);
      nmask[b]    = (NUM_W'(b) < n_q);
    end
  end

  // Free stretches at either end of the word
  always_comb begin
    lowfree = '0;
    hifree  = '0;
    stop_lo = 1'b0;
    stop_hi = 1'b0;
    for (int b = 0; b < DIGIT; b++) begin
      if (!stop_lo) begin
        if (taken[b]) stop_lo = 1'b1;
        else          lowfree = lowfree + CNT_W'(1);
      end
      if (!stop_hi) begin
        if (taken[DIGIT-1-b]) stop_hi = 1'b1;
        else                  hifree  = hifree + CNT_W'(1);
      end
    end
  end

  // Short runs lying wholly inside the word; lowest start wins
  always_comb begin
    n_small = (n_q <= NUM_W'(DIGIT));
    win_p   = '0;
    for (int p = 0; p < DIGIT; p++) begin
      win_ok[p] = n_small && ((NUM_W'(p) + n_q) <= NUM_W'(DIGIT)) &&
                  ((taken & (nmask << p)) == '0);
    end
    for (int p = DIGIT - 1; p >= 0; p--) begin
      if (win_ok[p]) win_p = DIG_SH'(p);
    end
    win_any  = |win_ok;
    run_ext  = {1'b0, run_q} + (NUM_W + 1)'(lowfree);
    cont_hit = (run_q != '0) && (run_ext >= {1'b0, n_q});
  end

  // Memory write port: clearing pass or run update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wi_q;
    mem_wd = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == S_MOD) begin
      mem_we = 1'b1;
      mem_wd = (kind_q == KIND_FREE) ? (rd_data_q & ~mod_mask) : (rd_data_q | mod_mask);
    end
  end

  // Free count after a release, saturating at capacity; new capacity and release end
  logic [XW:0]      free_sum;
  logic [FW-1:0]    free_nx;
  logic [XW-1:0]    free_x;
  logic [XW-1:0]    rsv_new_x, first_x, rel_end;
  logic [FW-1:0]    cap_new;
  always_comb begin
    free_sum = (XW + 1)'(free_q) + (XW + 1)'(added_q);
    if (kind_q == KIND_FREE && !fail_q) begin
      free_nx = (free_sum > (XW + 1)'(cap_q)) ? cap_q : FW'(free_sum);
    end else begin
      free_nx = free_q;
    end
    free_x    = XW'(free_nx);
    rsv_new_x = XW'(cfg_data_i);
    cap_new   = (rsv_new_x >= NUM_X) ? '0 : FW'(NUM_X - rsv_new_x);
    first_x   = XW'(first_q);
    rel_end   = first_x + XW'(n_q);
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      hdr_q    <= HDR_RESET;
      rsv_q    <= RSV_RESET;
      cap_q    <= FW'(NUM_UNITS - RSV_RESET);
      free_q   <= FW'(NUM_UNITS - RSV_RESET);
      kind_q   <= KIND_ALLOC;
      fail_q   <= 1'b0;
      first_q  <= '0;
      num_q    <= '0;
      n_q      <= '0;
      run_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      added_q  <= '0;
      wi_q     <= '0;
      rd_ptr_q <= '0;
      last_q   <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (wi_q == LAST_W) begin
            state_q <= S_IDLE;
          end else begin
            wi_q <= wi_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            kind_q  <= cmd_i.kind;
            first_q <= cmd_i.start_unit;
            num_q   <= NUM_W'(cmd_i.request_bytes) + NUM_W'(hdr_q) + UB_M1;
            rem_q   <= '0;
            n_q     <= '0;
            cnt_q   <= DCNT_W'(NUM_W - 1);
            fail_q  <= 1'b0;
            added_q <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? RW'(rem_sub) : RW'(rem_sh);
          n_q   <= {n_q[NUM_W-2:0], div_ge};
          num_q <= num_q << 1;
          if (cnt_q == '0) begin
            state_q <= S_CHECK;
          end else begin
            cnt_q <= cnt_q - DCNT_W'(1);
          end
        end
        S_CHECK: begin
          if (kind_q == KIND_ALLOC) begin
            if (n_q == '0 || n_q > NUM_W'(free_q)) begin
              fail_q  <= 1'b1;
              state_q <= S_DONE;
            end else begin
              run_q    <= '0;
              lo_q     <= '0;
              wi_q     <= '0;
              rd_ptr_q <= '0;
              state_q  <= S_SCANP;
            end
          end else begin
            lo_q    <= (first_x > XW'(rsv_q)) ? first_x : XW'(rsv_q);
            hi_q    <= (rel_end < NUM_X) ? rel_end : NUM_X;
            state_q <= S_RCNT;
          end
        end
        S_SCANP: begin
          rd_ptr_q <= (rd_ptr_q == LAST_W) ? '0 : rd_ptr_q + AW'(1);
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          rd_ptr_q <= (rd_ptr_q == LAST_W) ? '0 : rd_ptr_q + AW'(1);
          wi_q     <= wi_q + AW'(1);
          if (cont_hit) begin
            state_q <= S_FOUND;
          end else if (win_any) begin
            lo_q    <= base_x + XW'(win_p);
            state_q <= S_FOUND;
          end else begin
            if (taken == '0) begin
              if (run_q == '0) lo_q <= base_x;
              run_q <= run_q + NUM_W'(DIGIT);
            end else begin
              run_q <= NUM_W'(hifree);
              lo_q  <= base_x + XW'(DIGIT) - XW'(hifree);
            end
            if (wi_q == LAST_W) begin
              fail_q  <= 1'b1;
              state_q <= S_DONE;
            end
          end
        end
        S_FOUND: begin
          hi_q     <= lo_q + XW'(n_q);
          free_q   <= free_q - FW'(n_q);
          wi_q     <= lo_q[DIG_SH +: AW];
          rd_ptr_q <= lo_q[DIG_SH +: AW];
          state_q  <= S_MPRIME;
        end
        S_RCNT: begin
          if (hi_q > lo_q) begin
            added_q  <= hi_q - lo_q;
            wi_q     <= lo_q[DIG_SH +: AW];
            rd_ptr_q <= lo_q[DIG_SH +: AW];
            state_q  <= S_MPRIME;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_MPRIME: begin
          last_q   <= hi_q[DIG_SH +: AW] - AW'(hi_q[DIG_SH-1:0] == '0);
          rd_ptr_q <= (rd_ptr_q == LAST_W) ? '0 : rd_ptr_q + AW'(1);
          state_q  <= S_MOD;
        end
        S_MOD: begin
          if (wi_q == last_q) begin
            state_q <= S_DONE;
          end else begin
            wi_q     <= wi_q + AW'(1);
            rd_ptr_q <= (rd_ptr_q == LAST_W) ? '0 : rd_ptr_q + AW'(1);
          end
        end
        S_DONE: begin
          free_q              <= free_nx;
          done_q              <= 1'b1;
          res_q.status        <= fail_q ? STATUS_NO_SPACE : STATUS_OK;
          res_q.granted_unit  <= (fail_q || kind_q == KIND_FREE) ? '0 : lo_q[START_W-1:0];
          res_q.free_units    <= free_x[FREE_OUT_W-1:0];
          res_q.region_empty  <= (free_nx == cap_q);
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      // Register writes; reserved units restart the clearing pass
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEADER) begin
          hdr_q <= cfg_data_i[HDR_W-1:0];
        end else if (cfg_idx_i == CFG_RESERVED) begin
          rsv_q   <= cfg_data_i;
          cap_q   <= cap_new;
          free_q  <= cap_new;
          wi_q    <= '0;
          state_q <= S_CLEAR;
        end
      end
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_free_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= cap_q)
    else $error("free count above capacity");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == STATUS_NO_SPACE) |-> (res_q.granted_unit == '0))
    else $error("granted unit set on a failed allocation");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !done_q)
    else $error("result produced during clearing pass");

  a_alloc_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOUND && !cfg_we_i) |=> (free_q == $past(free_q) - FW'($past(n_q))))
    else $error("free count not lowered by the granted run");

endmodule
